// ----- sv/pfov_pkg.sv -----
`default_nettype none
package pfov_pkg;

    // Fixed widths of the ports and of the configuration data.
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int COORD_W     = 32;
    localparam int ROT_W       = 48;
    localparam int ENTRY_W     = 16;
    localparam int AZ_W        = 15;
    localparam int EL_W        = 14;

    // Square root: 64-bit radicand, 32 result bits, one bit per cell.
    localparam int RAD_W       = 64;
    localparam int ROOT_BITS   = 32;

    // CORDIC datapath.
    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int TABLE_LEN   = 24;
    localparam int PREP_W      = 34;
    localparam int CW          = 60;
    localparam int ZW          = 25;
    localparam int SCALE_SHIFT = 24;
    localparam int HALF_TURN   = 2949120;
    localparam int AZ_LIMIT    = 11520;
    localparam int EL_LIMIT    = 5760;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_X,
        REG_ROT_Y,
        REG_ROT_Z,
        REG_OFF_X,
        REG_OFF_Y,
        REG_OFF_Z,
        REG_FOV,
        REG_RANGE
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    // atan(2^-i) in 1/16384 degree, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:  v = ZW'(737280);
            1:  v = ZW'(435242);
            2:  v = ZW'(229970);
            3:  v = ZW'(116736);
            4:  v = ZW'(58595);
            5:  v = ZW'(29326);
            6:  v = ZW'(14667);
            7:  v = ZW'(7334);
            8:  v = ZW'(3667);
            9:  v = ZW'(1833);
            10: v = ZW'(917);
            11: v = ZW'(458);
            12: v = ZW'(229);
            13: v = ZW'(115);
            14: v = ZW'(57);
            15: v = ZW'(29);
            16: v = ZW'(14);
            17: v = ZW'(7);
            18: v = ZW'(4);
            19: v = ZW'(2);
            20: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Folds the vector into the right half plane and scales it up.
    function automatic cordic_t cordic_prep(input logic signed [PREP_W-1:0] x,
                                            input logic signed [PREP_W-1:0] y);
        cordic_t              p;
        logic signed [PREP_W-1:0] xn;
        logic signed [PREP_W-1:0] yn;
        logic signed [CW-1:0] xw;
        logic signed [CW-1:0] yw;
        p.zero = (x == '0) && (y == '0);
        if (x < 0)
        begin
            xn  = -x;
            yn  = -y;
            p.z = (y >= 0) ? ZW'(HALF_TURN) : -ZW'(HALF_TURN);
        end
        else
        begin
            xn  = x;
            yn  = y;
            p.z = '0;
        end
        xw  = CW'(xn);
        yw  = CW'(yn);
        p.x = xw <<< SCALE_SHIFT;
        p.y = yw <<< SCALE_SHIFT;
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- sv/pfov_xform.sv -----
`default_nettype none
module pfov_xform
(
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire pfov_pkg::point_t                     pt,
    input  wire logic [pfov_pkg::ROT_W-1:0]           rot_x,
    input  wire logic [pfov_pkg::ROT_W-1:0]           rot_y,
    input  wire logic [pfov_pkg::ROT_W-1:0]           rot_z,
    input  wire logic signed [pfov_pkg::COORD_W-1:0]  off_x,
    input  wire logic signed [pfov_pkg::COORD_W-1:0]  off_y,
    input  wire logic signed [pfov_pkg::COORD_W-1:0]  off_z,
    output pfov_pkg::point_t                          s_reg
);

    localparam int PW = pfov_pkg::ENTRY_W + pfov_pkg::COORD_W;

    logic signed [PW-1:0] prod_reg  [3][3];
    logic signed [PW-1:0] prod_next [3][3];
    pfov_pkg::point_t     s_next;

    logic [pfov_pkg::ROT_W-1:0]          rows [3];
    logic signed [pfov_pkg::COORD_W-1:0] offs [3];
    logic signed [pfov_pkg::COORD_W-1:0] comp [3];
    logic signed [pfov_pkg::COORD_W-1:0] res  [3];

    assign rows[0] = rot_x;
    assign rows[1] = rot_y;
    assign rows[2] = rot_z;
    assign offs[0] = off_x;
    assign offs[1] = off_y;
    assign offs[2] = off_z;
    assign comp[0] = pt.x;
    assign comp[1] = pt.y;
    assign comp[2] = pt.z;

    // First stage: the nine entry by coordinate products.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = PW'($signed(rows[r][c*pfov_pkg::ENTRY_W +: pfov_pkg::ENTRY_W]))
                                  * PW'(comp[c]);
            end
        end
    end

    // Second stage: row sums rounded half up to Q16.16, offset added, saturated.
    always_comb
    begin
        logic signed [PW+1:0] acc;
        logic signed [PW-12:0] rnd;
        logic signed [PW-11:0] sum;
        for (int r = 0; r < 3; r++)
        begin
            acc = (PW+2)'(prod_reg[r][0]) + (PW+2)'(prod_reg[r][1])
                  + (PW+2)'(prod_reg[r][2]) + (PW+2)'(8192);
            rnd = (PW-11)'(acc >>> 14);
            sum = (PW-10)'(rnd) + (PW-10)'(offs[r]);
            if (sum > (PW-10)'(32'sh7FFF_FFFF))
            begin
                res[r] = 32'sh7FFF_FFFF;
            end
            else if (sum < -(PW-10)'(64'sh8000_0000))
            begin
                res[r] = 32'sh8000_0000;
            end
            else
            begin
                res[r] = sum[pfov_pkg::COORD_W-1:0];
            end
        end
        s_next.x = res[0];
        s_next.y = res[1];
        s_next.z = res[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            s_reg    <= s_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/pfov_root_cell.sv -----
`default_nettype none
module pfov_root_cell
#(
    parameter int BIT = 31
)
(
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [pfov_pkg::RAD_W-1:0]          rem_in,
    input  wire logic [pfov_pkg::ROOT_BITS-1:0]      root_in,
    output logic [pfov_pkg::RAD_W-1:0]               rem_reg,
    output logic [pfov_pkg::ROOT_BITS-1:0]           root_reg
);

    localparam int TW = pfov_pkg::RAD_W + 2;

    logic [TW-1:0]                      trial;
    logic [pfov_pkg::RAD_W-1:0]         rem_next;
    logic [pfov_pkg::ROOT_BITS-1:0]     root_next;

    // Setting this bit adds 2*root*2^BIT + 4^BIT to the square.
    always_comb
    begin
        trial = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        if (TW'(rem_in) >= trial)
        begin
            rem_next  = rem_in - trial[pfov_pkg::RAD_W-1:0];
            root_next = root_in | (pfov_pkg::ROOT_BITS'(1) << BIT);
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/pfov_cordic_cell.sv -----
`default_nettype none
module pfov_cordic_cell
#(
    parameter int STEP = 0
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire pfov_pkg::cordic_t c_in,
    output pfov_pkg::cordic_t      c_reg
);

    pfov_pkg::cordic_t               c_next;
    logic signed [pfov_pkg::CW-1:0]  xs;
    logic signed [pfov_pkg::CW-1:0]  ys;

    // A non-negative y rotates clockwise.
    always_comb
    begin
        xs = $signed(c_in.x) >>> STEP;
        ys = $signed(c_in.y) >>> STEP;
        c_next.zero = c_in.zero;
        if (!c_in.y[pfov_pkg::CW-1])
        begin
            c_next.x = $signed(c_in.x) + ys;
            c_next.y = $signed(c_in.y) - xs;
            c_next.z = $signed(c_in.z) + pfov_pkg::atan_entry(STEP);
        end
        else
        begin
            c_next.x = $signed(c_in.x) - ys;
            c_next.y = $signed(c_in.y) + xs;
            c_next.z = $signed(c_in.z) - pfov_pkg::atan_entry(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/point_field_of_view_gate.sv -----
`default_nettype none
// Field-of-view gate. Each beat on the input carries one point in signed Q16.16 metres;
// the block rotates and offsets it into the sensor frame (saturating to 32 bits), takes the
// horizontal distance and the range as rounded square roots, finds azimuth and elevation in
// 1/64 degree by CORDIC, and returns one result beat per point with in_view set when all
// three lie inside their inclusive windows. It accepts one point every cycle while the output
// is not stalled; the result beat is presented once its point has passed through
// 40 + CORDIC_STEPS register stages (two transform stages, squares and sums, one square-root
// cell per result bit, rounding, CORDIC setup, one cell per CORDIC step, unit conversion and
// the output register). The whole pipeline advances together: it moves whenever the output
// register is empty or being taken, so in_ready falls only while a finished result waits.
// Configuration may be written only while no point is in flight.
module point_field_of_view_gate
#(
    parameter int CORDIC_STEPS = pfov_pkg::CORDIC_STEPS_DEFAULT
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [pfov_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pfov_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [pfov_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [pfov_pkg::COORD_W-1:0] point_y,
    input  wire logic signed [pfov_pkg::COORD_W-1:0] point_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     in_view,
    output logic signed [pfov_pkg::AZ_W-1:0]         azimuth,
    output logic signed [pfov_pkg::EL_W-1:0]         elevation,
    output logic [pfov_pkg::COORD_W-1:0]             range
);

    localparam int NB    = pfov_pkg::ROOT_BITS;
    localparam int NVLD  = 39 + CORDIC_STEPS;
    localparam int UW    = pfov_pkg::ZW - 7;

    // Configuration registers.
    logic [pfov_pkg::ROT_W-1:0]          rot_x_reg, rot_y_reg, rot_z_reg;
    logic signed [pfov_pkg::COORD_W-1:0] off_x_reg, off_y_reg, off_z_reg;
    logic [31:0]                         fov_reg;
    logic [63:0]                         rlim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg <= 48'd16384;
            rot_y_reg <= 48'd1073741824;
            rot_z_reg <= 48'd70368744177664;
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
            fov_reg   <= 32'd754997760;
            rlim_reg  <= 64'hFFFF_FFFF_0000_0000;
        end
        else if (cfg_we)
        begin
            unique case (pfov_pkg::cfg_reg_t'(cfg_index))
                pfov_pkg::REG_ROT_X: rot_x_reg <= cfg_data[pfov_pkg::ROT_W-1:0];
                pfov_pkg::REG_ROT_Y: rot_y_reg <= cfg_data[pfov_pkg::ROT_W-1:0];
                pfov_pkg::REG_ROT_Z: rot_z_reg <= cfg_data[pfov_pkg::ROT_W-1:0];
                pfov_pkg::REG_OFF_X: off_x_reg <= cfg_data[pfov_pkg::COORD_W-1:0];
                pfov_pkg::REG_OFF_Y: off_y_reg <= cfg_data[pfov_pkg::COORD_W-1:0];
                pfov_pkg::REG_OFF_Z: off_z_reg <= cfg_data[pfov_pkg::COORD_W-1:0];
                pfov_pkg::REG_FOV:   fov_reg   <= cfg_data[31:0];
                pfov_pkg::REG_RANGE: rlim_reg  <= cfg_data;
                default:             rot_x_reg <= rot_x_reg;
            endcase
        end
    end

    // Global advance: every stage moves when the output register can take a beat.
    logic en;
    logic out_valid_reg;
    logic [NVLD-1:0] vld_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NVLD-2:0], in_valid};
            out_valid_reg <= vld_reg[NVLD-1];
        end
    end

    // Rigid transform, two stages.
    pfov_pkg::point_t pt_in;
    pfov_pkg::point_t s_pt;

    assign pt_in.x = point_x;
    assign pt_in.y = point_y;
    assign pt_in.z = point_z;

    pfov_xform u_xform
    (
        .clk   (clk),
        .en    (en),
        .pt    (pt_in),
        .rot_x (rot_x_reg),
        .rot_y (rot_y_reg),
        .rot_z (rot_z_reg),
        .off_x (off_x_reg),
        .off_y (off_y_reg),
        .off_z (off_z_reg),
        .s_reg (s_pt)
    );

    // Squares, then the two sums of squares. The point rides along beside them.
    logic [pfov_pkg::RAD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [pfov_pkg::RAD_W-1:0] qh_reg, qr_reg;
    pfov_pkg::point_t           pt_reg [NB+3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg    <= pfov_pkg::RAD_W'(s_pt.x * s_pt.x);
            qy_reg    <= pfov_pkg::RAD_W'(s_pt.y * s_pt.y);
            qz_reg    <= pfov_pkg::RAD_W'(s_pt.z * s_pt.z);
            qh_reg    <= qx_reg + qy_reg;
            qr_reg    <= qx_reg + qy_reg + qz_reg;
            pt_reg[0] <= s_pt;
            for (int i = 1; i < NB + 3; i++)
            begin
                pt_reg[i] <= pt_reg[i-1];
            end
        end
    end

    // Two square-root chains, one result bit per cell, most significant first.
    logic [pfov_pkg::RAD_W-1:0] rem_h  [NB+1];
    logic [pfov_pkg::RAD_W-1:0] rem_r  [NB+1];
    logic [NB-1:0]              root_h [NB+1];
    logic [NB-1:0]              root_r [NB+1];

    assign rem_h[0]  = qh_reg;
    assign rem_r[0]  = qr_reg;
    assign root_h[0] = '0;
    assign root_r[0] = '0;

    for (genvar k = 0; k < NB; k++)
    begin : g_root
        pfov_root_cell #(.BIT(NB - 1 - k)) u_cell_h
        (
            .clk      (clk),
            .en       (en),
            .rem_in   (rem_h[k]),
            .root_in  (root_h[k]),
            .rem_reg  (rem_h[k+1]),
            .root_reg (root_h[k+1])
        );
        pfov_root_cell #(.BIT(NB - 1 - k)) u_cell_r
        (
            .clk      (clk),
            .en       (en),
            .rem_in   (rem_r[k]),
            .root_in  (root_r[k]),
            .rem_reg  (rem_r[k+1]),
            .root_reg (root_r[k+1])
        );
    end

    // Round to nearest: bump the root when the remainder exceeds it.
    logic [NB:0]   horiz_reg;
    logic [NB-1:0] rng_round;
    logic [NB:0]   rng33;

    assign rng33     = {1'b0, root_r[NB]}
                       + (NB+1)'(rem_r[NB] > pfov_pkg::RAD_W'(root_r[NB]));
    assign rng_round = rng33[NB] ? '1 : rng33[NB-1:0];

    // CORDIC chains for azimuth and elevation; the range follows alongside.
    pfov_pkg::cordic_t az_c [CORDIC_STEPS+1];
    pfov_pkg::cordic_t el_c [CORDIC_STEPS+1];
    logic [NB-1:0]     rng_reg [CORDIC_STEPS+3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            horiz_reg  <= {1'b0, root_h[NB]}
                          + (NB+1)'(rem_h[NB] > pfov_pkg::RAD_W'(root_h[NB]));
            rng_reg[0] <= rng_round;
            az_c[0]    <= pfov_pkg::cordic_prep(
                              pfov_pkg::PREP_W'(pt_reg[NB+2].x),
                              pfov_pkg::PREP_W'(pt_reg[NB+2].y));
            el_c[0]    <= pfov_pkg::cordic_prep(
                              pfov_pkg::PREP_W'($signed({1'b0, horiz_reg})),
                              pfov_pkg::PREP_W'(pt_reg[NB+2].z));
            rng_reg[1] <= rng_reg[0];
            for (int i = 2; i < CORDIC_STEPS + 3; i++)
            begin
                rng_reg[i] <= rng_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        pfov_cordic_cell #(.STEP(k)) u_az
        (
            .clk   (clk),
            .en    (en),
            .c_in  (az_c[k]),
            .c_reg (az_c[k+1])
        );
        pfov_cordic_cell #(.STEP(k)) u_el
        (
            .clk   (clk),
            .en    (en),
            .c_in  (el_c[k]),
            .c_reg (el_c[k+1])
        );
    end

    // Angle in 1/16384 degree to 1/64 degree, rounded half up and clamped; a zero vector gives zero.
    function automatic logic signed [UW-1:0] to_units(input pfov_pkg::cordic_t c,
                                                      input int lim);
        logic signed [pfov_pkg::ZW:0] s;
        logic signed [UW-1:0]         a;
        s = (pfov_pkg::ZW+1)'($signed(c.z)) + (pfov_pkg::ZW+1)'(128);
        a = UW'(s >>> 8);
        if (c.zero)
        begin
            a = '0;
        end
        else if (a > UW'(lim))
        begin
            a = UW'(lim);
        end
        else if (a < -UW'(lim))
        begin
            a = -UW'(lim);
        end
        return a;
    endfunction

    logic signed [pfov_pkg::AZ_W-1:0] az_reg;
    logic signed [pfov_pkg::EL_W-1:0] el_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_reg <= pfov_pkg::AZ_W'(to_units(az_c[CORDIC_STEPS], pfov_pkg::AZ_LIMIT));
            el_reg <= pfov_pkg::EL_W'(to_units(el_c[CORDIC_STEPS], pfov_pkg::EL_LIMIT));
        end
    end

    // Window test: twice the angle against the full field, so odd fields stay exact.
    logic               ok;
    logic signed [17:0] az2, el2, hfov, vfov;
    logic [NB-1:0]      rng_fin;

    assign rng_fin = rng_reg[CORDIC_STEPS+2];
    assign az2     = 18'(az_reg) <<< 1;
    assign el2     = 18'(el_reg) <<< 1;
    assign hfov    = $signed({2'b00, fov_reg[15:0]});
    assign vfov    = $signed({2'b00, fov_reg[31:16]});
    assign ok      = (az2 >= -hfov) && (az2 <= hfov)
                     && (el2 >= -vfov) && (el2 <= vfov)
                     && (rng_fin >= rlim_reg[31:0]) && (rng_fin <= rlim_reg[63:32]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_view   <= ok;
            azimuth   <= az_reg;
            elevation <= el_reg;
            range     <= rng_fin;
        end
    end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int  STEPS       = pfov_pkg::CORDIC_STEPS_DEFAULT;
    localparam int  LATENCY     = 40 + STEPS;
    localparam int  IDLE_LIMIT  = 4000;
    localparam int  SEGMENTS    = 8;
    localparam int  SEG_POINTS  = 205;
    localparam int  HOLD_CYCLES = 300;

    // Arctangent of 2^-i in 1/16384 degree, rounded to nearest.
    localparam longint ATAN_FINE [0:23] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0
    };

    // One result beat as the block returns it.
    typedef struct packed {
        logic                             iv;
        logic signed [pfov_pkg::AZ_W-1:0] az;
        logic signed [pfov_pkg::EL_W-1:0] el;
        logic [pfov_pkg::COORD_W-1:0]     rng;
    } view_t;

    // One row of the directed table: either a register write or a point.
    // Where lit is set, the expected beat is typed into the row.
    typedef struct packed {
        logic                         is_reg;
        pfov_pkg::cfg_reg_t           idx;
        logic [pfov_pkg::CFG_W-1:0]   data;
        logic [pfov_pkg::COORD_W-1:0] x;
        logic [pfov_pkg::COORD_W-1:0] y;
        logic [pfov_pkg::COORD_W-1:0] z;
        logic                         lit;
        view_t                        want;
    } row_t;

    localparam int ROWS = 25;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_we;
    logic [pfov_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [pfov_pkg::CFG_W-1:0]            cfg_data;
    logic                                  in_valid;
    logic                                  in_ready;
    logic signed [pfov_pkg::COORD_W-1:0]   point_x;
    logic signed [pfov_pkg::COORD_W-1:0]   point_y;
    logic signed [pfov_pkg::COORD_W-1:0]   point_z;
    logic                                  out_valid;
    logic                                  out_ready;
    logic                                  in_view;
    logic signed [pfov_pkg::AZ_W-1:0]      azimuth;
    logic signed [pfov_pkg::EL_W-1:0]      elevation;
    logic [pfov_pkg::COORD_W-1:0]          range;

    // Shadow copy of the configuration registers used by the predictor.
    logic [pfov_pkg::ROT_W-1:0] rot_rows [0:2];
    longint                     offsets  [0:2];
    logic [31:0]                fov_word;
    logic [63:0]                range_word;

    view_t               pending_views [$];
    int                  errors;
    int                  idle_cycles;
    bit                  calm;
    bit                  squeeze;

    point_field_of_view_gate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .in_view   (in_view),
        .azimuth   (azimuth),
        .elevation (elevation),
        .range     (range)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor. Every computation runs in 64-bit integers, which hold the
    // widest intermediate values: products of a Q2.14 entry and a Q16.16
    // coordinate, squares of saturated coordinates, and CORDIC vectors
    // scaled by 2^24.
    // ---------------------------------------------------------------------

    // One matrix row times the point, rounded half up to Q16.16, plus the
    // offset, then saturated to 32 signed bits.
    function automatic longint sensor_axis(input logic [pfov_pkg::ROT_W-1:0] row,
                                           input longint px,
                                           input longint py, input longint pz,
                                           input longint off);
        logic signed [pfov_pkg::ENTRY_W-1:0] e0;
        logic signed [pfov_pkg::ENTRY_W-1:0] e1;
        logic signed [pfov_pkg::ENTRY_W-1:0] e2;
        longint acc;
        e0  = row[15:0];
        e1  = row[31:16];
        e2  = row[47:32];
        acc = longint'(e0) * px + longint'(e1) * py + longint'(e2) * pz;
        acc = ((acc + 8192) >>> 14) + off;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc;
    endfunction

    // Integer square root rounded to the nearest whole value.
    function automatic longint unsigned nearest_root(input longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitpos;
        rem    = v;
        res    = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > rem)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (rem >= res + bitpos)
            begin
                rem = rem - (res + bitpos);
                res = (res >> 1) + bitpos;
            end
            else
            begin
                res = res >> 1;
            end
            bitpos = bitpos >> 2;
        end
        if (rem > res)
            res = res + 1;
        return res;
    endfunction

    // Vectoring CORDIC: atan2(y, x) in 1/16384 degree. A vector in the left
    // half plane is folded over first, starting the angle at plus or minus
    // a half turn; the zero vector gives zero.
    function automatic longint fine_angle(input longint x, input longint y);
        longint a;
        longint xs;
        longint ys;
        a = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            a = (y >= 0) ? longint'(pfov_pkg::HALF_TURN) : -longint'(pfov_pkg::HALF_TURN);
            x = -x;
            y = -y;
        end
        x = x <<< 24;
        y = y <<< 24;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                a = a + ATAN_FINE[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                a = a - ATAN_FINE[i];
            end
        end
        return a;
    endfunction

    // Rounds half up to 1/64 degree and clamps any overshoot.
    function automatic longint coarse_angle(input longint a, input longint lim);
        longint u;
        u = (a + 128) >>> 8;
        if (u > lim)
            u = lim;
        if (u < -lim)
            u = -lim;
        return u;
    endfunction

    function automatic view_t gate_point(input logic [pfov_pkg::COORD_W-1:0] x,
                                         input logic [pfov_pkg::COORD_W-1:0] y,
                                         input logic [pfov_pkg::COORD_W-1:0] z);
        longint          px;
        longint          py;
        longint          pz;
        longint          sx;
        longint          sy;
        longint          sz;
        longint unsigned qx;
        longint unsigned qy;
        longint unsigned qz;
        longint          horiz;
        longint unsigned reach;
        longint          az;
        longint          el;
        longint          hfov;
        longint          vfov;
        longint unsigned rmin;
        longint unsigned rmax;
        view_t           v;
        px    = longint'($signed(x));
        py    = longint'($signed(y));
        pz    = longint'($signed(z));
        sx    = sensor_axis(rot_rows[0], px, py, pz, offsets[0]);
        sy    = sensor_axis(rot_rows[1], px, py, pz, offsets[1]);
        sz    = sensor_axis(rot_rows[2], px, py, pz, offsets[2]);
        qx    = longint'(sx * sx);
        qy    = longint'(sy * sy);
        qz    = longint'(sz * sz);
        horiz = longint'(nearest_root(qx + qy));
        reach = nearest_root(qx + qy + qz);
        if (reach > 64'hFFFF_FFFF)
            reach = 64'hFFFF_FFFF;
        az    = coarse_angle(fine_angle(sx, sy), pfov_pkg::AZ_LIMIT);
        el    = coarse_angle(fine_angle(horiz, sz), pfov_pkg::EL_LIMIT);
        hfov  = longint'(fov_word[15:0]);
        vfov  = longint'(fov_word[31:16]);
        rmin  = range_word[31:0];
        rmax  = range_word[63:32];
        // The window test doubles the angle so that an odd full angle is exact.
        v.iv  = (2 * az >= -hfov) && (2 * az <= hfov) && (2 * el >= -vfov) &&
                (2 * el <= vfov) && (reach >= rmin) && (reach <= rmax);
        v.az  = az[pfov_pkg::AZ_W-1:0];
        v.el  = el[pfov_pkg::EL_W-1:0];
        v.rng = reach[31:0];
        return v;
    endfunction

    // ---------------------------------------------------------------------
    // Driving. All inputs change at the falling edge; acceptance is judged
    // at the rising edge from the values that held just before it.
    // ---------------------------------------------------------------------

    // Writes one register and mirrors it into the predictor. Call at a
    // falling edge while nothing is in flight.
    task automatic write_reg(input pfov_pkg::cfg_reg_t idx,
                             input logic [pfov_pkg::CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            pfov_pkg::REG_ROT_X: rot_rows[0] = data[pfov_pkg::ROT_W-1:0];
            pfov_pkg::REG_ROT_Y: rot_rows[1] = data[pfov_pkg::ROT_W-1:0];
            pfov_pkg::REG_ROT_Z: rot_rows[2] = data[pfov_pkg::ROT_W-1:0];
            pfov_pkg::REG_OFF_X: offsets[0]  = longint'($signed(data[31:0]));
            pfov_pkg::REG_OFF_Y: offsets[1]  = longint'($signed(data[31:0]));
            pfov_pkg::REG_OFF_Z: offsets[2]  = longint'($signed(data[31:0]));
            pfov_pkg::REG_FOV:   fov_word    = data[31:0];
            pfov_pkg::REG_RANGE: range_word  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Waits until every expected beat has come back, so that the block is
    // idle before the configuration changes.
    task automatic drain;
        in_valid = 1'b0;
        while (pending_views.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Offers one point and holds it until it is taken. Called at a falling
    // edge and returns at one. Outside the final stretch, a random gap with
    // in_valid low may follow the beat.
    task automatic send_point(input logic [pfov_pkg::COORD_W-1:0] x,
                              input logic [pfov_pkg::COORD_W-1:0] y,
                              input logic [pfov_pkg::COORD_W-1:0] z, input logic lit,
                              input view_t want);
        view_t next_view;
        point_x  = x;
        point_y  = y;
        point_z  = z;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        next_view     = lit ? want : gate_point(x, y, z);
        pending_views = {pending_views, next_view};
        @(negedge clk);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    // Receiver side: ready drops in random bursts, and once for a long hold
    // so that the pipeline fills and the block stalls its input.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                squeeze = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Checking and watchdog.
    // ---------------------------------------------------------------------

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch in %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        view_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_views.size() == 0)
            begin
                report("unexpected beat", 1, 0);
            end
            else
            begin
                w = pending_views.pop_front();
                if (in_view !== w.iv)
                    report("in_view", longint'(in_view), longint'(w.iv));
                if (azimuth !== w.az)
                    report("azimuth", longint'(azimuth), longint'(w.az));
                if (elevation !== w.el)
                    report("elevation", longint'(elevation), longint'(w.el));
                if (range !== w.rng)
                    report("range", longint'(range), longint'(w.rng));
            end
        end
    end

    // Counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Random choices.
    // ---------------------------------------------------------------------

    // Mostly wide random coordinates, with a share of small values where
    // angles resolve finely and of the two extremes and zero.
    function automatic logic [pfov_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 6))
            0, 1:    return $urandom;
            2, 3:    return int'($urandom_range(0, 2097152)) - 1048576;
            4:       return int'($urandom_range(0, 255)) - 128;
            5:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return '0;
        endcase
    endfunction

    // A matrix row: usually a signed unit entry in one column with small
    // noise elsewhere, sometimes fully random.
    function automatic logic [pfov_pkg::ROT_W-1:0] pick_row();
        logic [pfov_pkg::ENTRY_W-1:0] e [0:2];
        int                           col;
        if ($urandom_range(0, 3) == 0)
            return pfov_pkg::ROT_W'({$urandom, $urandom});
        col = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
            e[i] = pfov_pkg::ENTRY_W'(int'($urandom_range(0, 64)) - 32);
        e[col] = $urandom_range(0, 1) ? 16'd16384 : -16'sd16384;
        return {e[2], e[1], e[0]};
    endfunction

    task automatic random_setup;
        logic [31:0] lo;
        logic [31:0] hi;
        write_reg(pfov_pkg::REG_ROT_X, pick_row());
        write_reg(pfov_pkg::REG_ROT_Y, pick_row());
        write_reg(pfov_pkg::REG_ROT_Z, pick_row());
        write_reg(pfov_pkg::REG_OFF_X, {32'd0, pick_coord()});
        write_reg(pfov_pkg::REG_OFF_Y, {32'd0, pick_coord()});
        write_reg(pfov_pkg::REG_OFF_Z, {32'd0, pick_coord()});
        if ($urandom_range(0, 1))
            write_reg(pfov_pkg::REG_FOV, {32'd0, $urandom});
        else
            write_reg(pfov_pkg::REG_FOV, {32'd0, 16'($urandom_range(0, 11520)),
                                          16'($urandom_range(0, 23040))});
        lo = $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 20)) : $urandom;
        hi = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF;
        // Now and then the minimum lies above the maximum and nothing passes.
        if ($urandom_range(0, 7) == 0)
            write_reg(pfov_pkg::REG_RANGE, {lo, hi});
        else
            write_reg(pfov_pkg::REG_RANGE, {hi, lo});
    endtask

    // ---------------------------------------------------------------------
    // Directed table. At reset: identity, zero offset, 360 by 180 degree fields, the full range.
    // The zero point is known without working: the three numbers are zero and in_view is set.
    // ---------------------------------------------------------------------
    localparam view_t NONE  = '0;
    localparam view_t ZERO  = '{iv: 1'b1, az: '0, el: '0, rng: '0};
    localparam view_t SHUT  = '{iv: 1'b0, az: '0, el: '0, rng: '0};

    localparam row_t DIRECTED [0:ROWS-1] = '{
        // Zero vector at reset settings.
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, 32'd0, 32'd0, 32'd0, 1'b1, ZERO},
        // Axis points, including negative x with y zero and with y negative.
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, 32'd65536, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, -32'sd65536, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, -32'sd65536, -32'sd1, 32'd0, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, 32'd0, 32'd65536, 32'd0, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, 32'd0, -32'sd65536, 32'd0, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, 32'd0, 32'd0, 32'd65536, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, 32'd0, 32'd0, -32'sd65536, 1'b0, NONE},
        // Coordinate extremes.
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0,
          32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 1'b0, NONE},
        // Minimum range of one: the zero point falls out of view.
        '{1'b1, pfov_pkg::REG_RANGE, 64'hFFFF_FFFF_0000_0001,
          32'd0, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, 32'd0, 32'd0, 32'd0, 1'b1, SHUT},
        // Extreme matrix entries and offsets saturate the transform.
        '{1'b1, pfov_pkg::REG_ROT_X, 64'h7FFF_7FFF_7FFF, 32'd0, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b1, pfov_pkg::REG_ROT_Y, 64'h8000_8000_8000, 32'd0, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b1, pfov_pkg::REG_ROT_Z, 64'h7FFF_0000_8000, 32'd0, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b1, pfov_pkg::REG_OFF_X, 64'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b1, pfov_pkg::REG_OFF_Y, 64'h8000_0000, 32'd0, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b1, pfov_pkg::REG_OFF_Z, 64'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b0, NONE},
        // Odd full angles of one unit, and minimum range above maximum.
        '{1'b1, pfov_pkg::REG_FOV, 64'h0001_0001, 32'd0, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b1, pfov_pkg::REG_RANGE, 64'h0000_0000_FFFF_FFFF,
          32'd0, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0,
          32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0, NONE},
        // Widest windows.
        '{1'b1, pfov_pkg::REG_FOV, 64'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0, NONE},
        '{1'b0, pfov_pkg::REG_ROT_X, 64'd0, -32'sd3, 32'd40000, 32'h0010_0000, 1'b0, NONE}
    };

    // ---------------------------------------------------------------------
    // Main sequence: reset, the directed table, then random segments, each
    // under a fresh configuration. The second segment carries the long
    // receiver hold; the last runs with both sides always ready.
    // ---------------------------------------------------------------------
    initial
    begin
        row_t r;
        errors      = 0;
        calm        = 1'b0;
        squeeze     = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        point_x     = '0;
        point_y     = '0;
        point_z     = '0;
        rot_rows[0] = 48'd16384;
        rot_rows[1] = 48'd16384 << 16;
        rot_rows[2] = 48'd16384 << 32;
        offsets[0]  = 0;
        offsets[1]  = 0;
        offsets[2]  = 0;
        fov_word    = 32'd754997760;
        range_word  = 64'hFFFF_FFFF_0000_0000;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < ROWS; i++)
        begin
            r = DIRECTED[i];
            if (r.is_reg)
            begin
                drain();
                write_reg(r.idx, r.data);
            end
            else
            begin
                send_point(r.x, r.y, r.z, r.lit, r.want);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            random_setup();
            if (seg == 1)
                squeeze = 1'b1;
            if (seg == SEGMENTS - 1)
                calm = 1'b1;
            for (int n = 0; n < SEG_POINTS; n++)
                send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0, NONE);
        end

        in_valid = 1'b0;
        while (pending_views.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
